// ----- hw/rtl/tle_pkg.sv -----
// ----------------------------------------------------------------------------
// Terminal line editor package
// Shared constants, payload types and controller/datapath command structs.
// ----------------------------------------------------------------------------
package tle_pkg;

   localparam int unsigned LineMax = 24;
   localparam int unsigned PosW    = 5;
   localparam int unsigned IdxW    = $clog2(LineMax);

   localparam logic [7:0] KeyEnter = 8'd13;
   localparam logic [7:0] KeyBs    = 8'd127;
   localparam logic [7:0] KeyEsc   = 8'd27;
   localparam logic [7:0] ChSpace  = 8'd32;
   localparam logic [7:0] ChBack   = 8'd8;
   localparam logic [7:0] ChNl     = 8'd10;
   localparam logic [7:0] ChLbr    = 8'd91;
   localparam logic [7:0] ChA      = 8'd65;
   localparam logic [7:0] ChB      = 8'd66;
   localparam logic [7:0] ChC      = 8'd67;
   localparam logic [7:0] ChD      = 8'd68;
   localparam logic [7:0] Ch3      = 8'd51;
   localparam logic [7:0] ChTilde  = 8'd126;
   localparam logic [4:0] CapReset = 5'd24;

   typedef struct packed {
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic       target;
      logic [7:0] byte_value;
      logic       overflow;
      logic       last;
   } rsp_type;

   // Write data source for the line store.
   typedef enum logic [1:0] {
      SRC_CONST,
      SRC_STORE,
      SRC_INPUT
   } src_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic            wr_en;
      logic [IdxW-1:0] wr_addr;
      src_type         wr_src;
      logic [IdxW-1:0] rd_addr;
   } cmd_type;

   // Datapath status.
   typedef struct packed {
      logic [7:0] rd_data;
   } sts_type;

endpackage

// ----- hw/rtl/tle_if.sv -----
// ----------------------------------------------------------------------------
// Terminal line editor channel interfaces
// Valid/ready channels for keystroke and result items.
// ----------------------------------------------------------------------------
interface tle_req_if;
   logic             valid;
   logic             ready;
   tle_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface tle_rsp_if;
   logic             valid;
   logic             ready;
   tle_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/tle_datapath.sv -----
// ----------------------------------------------------------------------------
// Terminal line editor datapath
// Line storage with one write port and one registered read port.
// ----------------------------------------------------------------------------
module tle_datapath (
   input  logic             clock,
   input  tle_pkg::cmd_type cmd,
   input  logic [7:0]       in_byte,
   output tle_pkg::sts_type sts
);

   logic [7:0] mem [tle_pkg::LineMax];
   logic [7:0] rd_ff;
   logic [7:0] wdata;

   always_comb begin
      if (cmd.wr_src == tle_pkg::SRC_INPUT) begin
         wdata = in_byte;
      end else begin
         wdata = rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= wdata;
      end
      rd_ff <= mem[cmd.rd_addr];
   end

   assign sts.rd_data = rd_ff;

endmodule

// ----- hw/rtl/tle_ctrl.sv -----
// ----------------------------------------------------------------------------
// Terminal line editor controller
// Decodes keys, sequences line shifts and emits echo and commit items.
// ----------------------------------------------------------------------------
module tle_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_byte,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tle_pkg::rsp_type rsp_payload,
   input  logic             csr_we,
   input  logic [4:0]       csr_wdata,
   output tle_pkg::cmd_type cmd,
   output logic [7:0]       cur_byte,
   input  tle_pkg::sts_type sts
);

   localparam int unsigned PW = tle_pkg::PosW;
   localparam int unsigned IW = tle_pkg::IdxW;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INS_SHIFT,   // move one stored byte right, tail end first
      S_RD,          // issue read, wait for data
      S_EMIT,        // present a store byte
      S_CONST,       // present a constant byte
      S_DEL_SHIFT,   // move one stored byte left and echo it
      S_ESC_OUT
   } state_type;

   typedef enum logic [2:0] {
      J_TAIL,        // insert: redraw tail then backspaces
      J_COMMIT,      // commit bytes then newline
      J_DEL,         // delete: shift left then space then backspaces
      J_NONE
   } job_type;

   state_type   state_ff, state_in;
   job_type     job_ff, job_in;
   logic [PW-1:0] len_ff, len_in, cur_ff, cur_in, idx_ff, idx_in, cnt_ff, cnt_in;
   logic [PW-1:0] cap_ff, cap_in;
   logic [1:0]  esc_ff, esc_in;
   logic        ovf_ff, ovf_in;
   logic [7:0]  byte_ff, byte_in;
   logic [1:0]  ph_ff, ph_in;     // sub-phase inside a job
   logic        pend_ff, pend_in; // result presented
   tle_pkg::rsp_type out_ff, out_in;
   logic [PW-1:0] ecap;

   always_comb begin
      if (cap_ff == '0) ecap = PW'(1);
      else if (cap_ff > PW'(tle_pkg::LineMax)) ecap = PW'(tle_pkg::LineMax);
      else ecap = cap_ff;
   end

   assign req_ready   = (state_ff == S_IDLE) && !pend_ff;
   assign rsp_valid   = pend_ff;
   assign rsp_payload = out_ff;
   assign cur_byte    = byte_ff;

   always_comb begin
      logic [PW-1:0] l;
      logic [PW-1:0] c;
      logic          fin;
      state_in = state_ff; job_in = job_ff; len_in = len_ff; cur_in = cur_ff;
      idx_in = idx_ff; cnt_in = cnt_ff; cap_in = cap_ff; esc_in = esc_ff;
      ovf_in = ovf_ff; byte_in = byte_ff; ph_in = ph_ff; pend_in = pend_ff;
      out_in = out_ff;
      cmd = '0;
      cmd.wr_src = tle_pkg::SRC_STORE;
      cmd.rd_addr = idx_ff[IW-1:0];
      l = len_ff; c = cur_ff; fin = 1'b0;
      if (csr_we) cap_in = csr_wdata;
      if (pend_ff && rsp_ready) pend_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready && req_byte != 8'd0) begin
               byte_in = req_byte;
               if (esc_ff == 2'd1) begin
                  esc_in = 2'd2;
               end else if (esc_ff == 2'd2) begin
                  if (req_byte == tle_pkg::ChC) begin
                     esc_in = 2'd0;
                     if (cur_ff < len_ff) begin
                        cur_in = cur_ff + 1'b1; state_in = S_ESC_OUT; ph_in = 2'd0;
                     end
                  end else if (req_byte == tle_pkg::ChD) begin
                     esc_in = 2'd0;
                     if (cur_ff != '0) begin
                        cur_in = cur_ff - 1'b1; state_in = S_ESC_OUT; ph_in = 2'd0;
                     end
                  end else if (req_byte == tle_pkg::ChA || req_byte == tle_pkg::ChB) begin
                     esc_in = 2'd0;
                  end else if (req_byte == tle_pkg::Ch3) begin
                     esc_in = 2'd3;
                  end
               end else if (esc_ff == 2'd3) begin
                  if (req_byte == tle_pkg::ChTilde) begin
                     esc_in = 2'd0;
                     if (cur_ff < len_ff) begin
                        job_in = J_DEL; idx_in = cur_ff; state_in = S_DEL_SHIFT; ph_in = 2'd0;
                     end
                  end
               end else if (req_byte == tle_pkg::KeyEnter) begin
                  job_in = J_COMMIT; ovf_in = 1'b0; idx_in = '0;
                  state_in = (len_ff == '0) ? S_CONST : S_RD;
               end else if (req_byte == tle_pkg::KeyBs) begin
                  if (len_ff != '0 && cur_ff != '0 && cur_ff <= len_ff) begin
                     // backspace echo first, then same as delete at cursor-1
                     job_in = J_DEL; cur_in = cur_ff - 1'b1; idx_in = cur_ff - 1'b1;
                     state_in = S_CONST; ph_in = 2'd3;
                  end
               end else if (req_byte == tle_pkg::KeyEsc) begin
                  esc_in = 2'd1;
               end else begin
                  if (l >= PW'(tle_pkg::LineMax)) l = PW'(tle_pkg::LineMax - 1);
                  if (c > l) c = l;
                  len_in = l; cur_in = c; idx_in = l;
                  state_in = S_INS_SHIFT; ph_in = 2'd0;
               end
            end
         end
         S_INS_SHIFT: begin
            // idx: destination; ph0 read idx-1, ph1 write
            if (idx_ff == cur_ff) begin
               cmd.wr_en = 1'b1; cmd.wr_addr = idx_ff[IW-1:0];
               cmd.wr_src = tle_pkg::SRC_INPUT;
               len_in = len_ff + 1'b1; cur_in = cur_ff + 1'b1;
               if (len_ff + 1'b1 >= ecap) begin
                  job_in = J_COMMIT; ovf_in = 1'b1; idx_in = '0; state_in = S_RD;
               end else begin
                  job_in = J_TAIL; ovf_in = 1'b0; idx_in = cur_ff;
                  cnt_in = len_ff - cur_ff; state_in = S_RD;
               end
            end else if (ph_ff == 2'd0) begin
               cmd.rd_addr = IW'(idx_ff - 1'b1); ph_in = 2'd1;
            end else begin
               cmd.wr_en = 1'b1; cmd.wr_addr = idx_ff[IW-1:0];
               idx_in = idx_ff - 1'b1; ph_in = 2'd0;
            end
         end
         S_RD: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!pend_ff || rsp_ready) begin
               pend_in = 1'b1;
               out_in.byte_value = sts.rd_data;
               out_in.target = (job_ff == J_COMMIT);
               out_in.overflow = ovf_ff && (job_ff == J_COMMIT);
               out_in.last = 1'b0;
               idx_in = idx_ff + 1'b1;
               if (idx_ff + 1'b1 >= len_ff) begin
                  state_in = S_CONST; ph_in = 2'd0;
                  if (job_ff == J_TAIL && cnt_ff == '0) out_in.last = 1'b1;
                  if (job_ff == J_TAIL && cnt_ff == '0) state_in = S_IDLE;
               end else begin
                  state_in = S_RD;
               end
            end
         end
         S_DEL_SHIFT: begin
            // ph0 read idx+1, ph1 wait, ph2 write+echo. The read address is held
            // on idx+1 in every phase so the read data stays on that byte.
            cmd.rd_addr = IW'(idx_ff + 1'b1);
            if (idx_ff + 1'b1 >= len_ff) begin
               state_in = S_CONST; ph_in = 2'd1; cnt_in = len_ff - cur_ff;
            end else if (ph_ff == 2'd0) begin
               ph_in = 2'd1;
            end else if (ph_ff == 2'd1) begin
               ph_in = 2'd2;
            end else if (!pend_ff || rsp_ready) begin
               cmd.wr_en = 1'b1; cmd.wr_addr = idx_ff[IW-1:0];
               pend_in = 1'b1;
               out_in = '{target: 1'b0, byte_value: sts.rd_data, overflow: 1'b0, last: 1'b0};
               idx_in = idx_ff + 1'b1; ph_in = 2'd0;
            end
         end
         S_CONST: begin
            if (!pend_ff || rsp_ready) begin
               pend_in = 1'b1;
               out_in = '{target: 1'b0, byte_value: tle_pkg::ChBack, overflow: 1'b0,
                          last: 1'b0};
               case (job_ff)
                  J_COMMIT: begin
                     out_in.byte_value = tle_pkg::ChNl; out_in.overflow = ovf_ff;
                     out_in.last = 1'b1; fin = 1'b1;
                     len_in = '0; cur_in = '0;
                  end
                  J_TAIL: begin
                     cnt_in = cnt_ff - 1'b1;
                     if (cnt_ff == PW'(1)) begin
                        out_in.last = 1'b1; fin = 1'b1;
                     end
                  end
                  J_DEL: begin
                     if (ph_ff == 2'd3) begin
                        // leading backspace of backspace key
                        state_in = S_DEL_SHIFT; ph_in = 2'd0;
                     end else if (ph_ff == 2'd1) begin
                        out_in.byte_value = tle_pkg::ChSpace; ph_in = 2'd2;
                     end else begin
                        cnt_in = cnt_ff - 1'b1;
                        if (cnt_ff == PW'(1)) begin
                           out_in.last = 1'b1; fin = 1'b1; len_in = len_ff - 1'b1;
                        end
                     end
                  end
                  default: fin = 1'b1;
               endcase
               if (fin) state_in = S_IDLE;
            end
         end
         S_ESC_OUT: begin
            if (!pend_ff || rsp_ready) begin
               pend_in = 1'b1;
               out_in = '{target: 1'b0, byte_value: tle_pkg::KeyEsc, overflow: 1'b0,
                          last: 1'b0};
               ph_in = ph_ff + 1'b1;
               if (ph_ff == 2'd1) out_in.byte_value = tle_pkg::ChLbr;
               if (ph_ff == 2'd2) begin
                  out_in.byte_value = byte_ff; out_in.last = 1'b1; state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; job_ff <= J_NONE; len_ff <= '0; cur_ff <= '0;
         esc_ff <= '0; cap_ff <= tle_pkg::CapReset; pend_ff <= 1'b0;
         idx_ff <= '0; cnt_ff <= '0; ph_ff <= '0; ovf_ff <= 1'b0;
      end else begin
         state_ff <= state_in; job_ff <= job_in; len_ff <= len_in; cur_ff <= cur_in;
         esc_ff <= esc_in; cap_ff <= cap_in; pend_ff <= pend_in;
         idx_ff <= idx_in; cnt_ff <= cnt_in; ph_ff <= ph_in; ovf_ff <= ovf_in;
      end
      byte_ff <= byte_in;
      out_ff  <= out_in;
   end

endmodule

// ----- hw/rtl/terminal_line_editor.sv -----
// ----------------------------------------------------------------------------
// Terminal line editor
// Keystroke line editing with terminal echo and committed line delivery.
// ----------------------------------------------------------------------------
//  Channel   Direction  Carries
//  req       in         one received keystroke byte per item
//  rsp       out        echo or committed line byte, overflow and last flags
//  csr       in         line capacity register, write only
//
// One keystroke item is handled at a time. After acceptance, an insertion
// shifts stored bytes right one at a time with a read then a write; a
// delete or backspace shifts them left with a read, a wait, then a write
// and echo; a redraw or commit reads each stored byte before presenting it;
// constant results (backspace, space, newline, escape echo) go out directly.
// The single read port of the line store paces these shifts and reads.
// Reset clears the cursor, length, escape phase and capacity (to 24); the
// line store holds no reset value. A stalled rsp holds the controller at the
// current result, and no new item is taken while a result is waiting.
// ----------------------------------------------------------------------------
module terminal_line_editor (
   input logic     clock,
   input logic     reset,
   tle_req_if.sink   req,
   tle_rsp_if.source rsp,
   input logic       csr_we,
   input logic [4:0] csr_wdata
);

   tle_pkg::cmd_type cmd;
   tle_pkg::sts_type sts;
   logic [7:0]       cur_byte;

   // The controller owns all sequencing; the datapath owns the line store.
   tle_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req.valid),
      .req_ready   (req.ready),
      .req_byte    (req.payload.rx_byte),
      .rsp_valid   (rsp.valid),
      .rsp_ready   (rsp.ready),
      .rsp_payload (rsp.payload),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .cur_byte    (cur_byte),
      .sts         (sts)
   );

   tle_datapath u_datapath (
      .clock   (clock),
      .cmd     (cmd),
      .in_byte (cur_byte),
      .sts     (sts)
   );

endmodule

// ----- dv/tb_terminal_line_editor.sv -----
// ----------------------------------------------------------------------------
// Terminal line editor testbench
// Drives keystroke items into the editor, predicts the echo and committed
// line bytes from its own line model, and checks every result item in order.
// ----------------------------------------------------------------------------
module tb_terminal_line_editor;

   localparam int unsigned TailCycles = 200;
   localparam int unsigned CycleLimit = 800000;
   localparam int unsigned LongHold   = 500;

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic [4:0] csr_wdata;

   tle_req_if req_ch ();
   tle_rsp_if rsp_ch ();

   terminal_line_editor dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Keystrokes waiting to be offered, and result items the line model expects.
   logic [7:0]       key_queue[$];
   tle_pkg::rsp_type echo_expect_q[$];

   // Line model state.
   logic [7:0] line_buf[tle_pkg::LineMax];
   int unsigned line_len;
   int unsigned cursor;
   int unsigned esc_phase;
   logic [4:0]  capacity;

   int unsigned err_count;
   int unsigned send_gap;
   int unsigned recv_wait;
   int unsigned hold_left;
   int unsigned cycle_count;
   bit          no_idle;
   bit          long_hold_arm;
   bit          long_hold_done;
   int unsigned result_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Gap before an item on either side; some phases run with no gaps at all.
   function automatic int unsigned idle_draw();
      return no_idle ? 0 : $urandom_range(0, 9);
   endfunction

   // ------------------------------------------------------------------------
   // Line model. Each call appends the result items one keystroke causes.
   // ------------------------------------------------------------------------
   task automatic emit(input logic tgt, input logic [7:0] b, input logic ovf);
      tle_pkg::rsp_type r;
      r.target     = tgt;
      r.byte_value = b;
      r.overflow   = ovf;
      r.last       = 1'b0;
      echo_expect_q.push_back(r);
      result_count++;
   endtask

   task automatic commit_line(input logic ovf);
      for (int unsigned i = 0; i < line_len; i++) emit(1'b1, line_buf[i], ovf);
      emit(1'b0, tle_pkg::ChNl, ovf);
      line_len = 0;
      cursor   = 0;
   endtask

   task automatic insert_key(input logic [7:0] b);
      int unsigned eff_cap;
      int unsigned len;
      int unsigned c;
      eff_cap = (capacity == 0) ? 1 :
                (capacity > tle_pkg::LineMax) ? tle_pkg::LineMax : capacity;
      len = (line_len >= tle_pkg::LineMax) ? tle_pkg::LineMax - 1 : line_len;
      c   = (cursor > len) ? len : cursor;
      for (int unsigned i = len; i > c; i--) line_buf[i] = line_buf[i-1];
      line_buf[c] = b;
      line_len = len + 1;
      cursor   = c + 1;
      // A line that reaches capacity is delivered instead of redrawn.
      if (line_len >= eff_cap) begin
         commit_line(1'b1);
         return;
      end
      for (int unsigned i = c; i <= len; i++) emit(1'b0, line_buf[i], 1'b0);
      for (int unsigned i = len; i > c; i--) emit(1'b0, tle_pkg::ChBack, 1'b0);
   endtask

   // Shared by backspace and delete: close the gap at position c and redraw.
   task automatic close_gap(input int unsigned c, input int unsigned len);
      for (int unsigned i = c; i + 1 < len; i++) begin
         line_buf[i] = line_buf[i+1];
         emit(1'b0, line_buf[i], 1'b0);
      end
      emit(1'b0, tle_pkg::ChSpace, 1'b0);
      for (int unsigned i = len; i > c; i--) emit(1'b0, tle_pkg::ChBack, 1'b0);
      line_len = len - 1;
   endtask

   task automatic cursor_move(input logic [7:0] dir);
      emit(1'b0, tle_pkg::KeyEsc, 1'b0);
      emit(1'b0, tle_pkg::ChLbr, 1'b0);
      emit(1'b0, dir, 1'b0);
   endtask

   task automatic predict_key(input logic [7:0] b);
      int unsigned n0;
      n0 = result_count;
      if (b == 8'd0) return;
      if (esc_phase == 1) begin
         // The byte after ESC is taken as the bracket, whatever it is.
         esc_phase = 2;
      end else if (esc_phase == 2) begin
         if (b == tle_pkg::ChC) begin
            esc_phase = 0;
            if (cursor < line_len) begin
               cursor_move(tle_pkg::ChC);
               cursor++;
            end
         end else if (b == tle_pkg::ChD) begin
            esc_phase = 0;
            if (cursor > 0) begin
               cursor_move(tle_pkg::ChD);
               cursor--;
            end
         end else if (b == tle_pkg::ChA || b == tle_pkg::ChB) begin
            esc_phase = 0;
         end else if (b == tle_pkg::Ch3) begin
            esc_phase = 3;
         end
      end else if (esc_phase == 3) begin
         if (b == tle_pkg::ChTilde) begin
            esc_phase = 0;
            if (cursor < line_len) close_gap(cursor, line_len);
         end
      end else if (b == tle_pkg::KeyEnter) begin
         commit_line(1'b0);
      end else if (b == tle_pkg::KeyBs) begin
         if (line_len != 0 && cursor != 0 && cursor <= line_len) begin
            emit(1'b0, tle_pkg::ChBack, 1'b0);
            cursor--;
            close_gap(cursor, line_len);
         end
      end else if (b == tle_pkg::KeyEsc) begin
         esc_phase = 1;
      end else begin
         insert_key(b);
      end
      if (result_count != n0) echo_expect_q[echo_expect_q.size()-1].last = 1'b1;
   endtask

   // ------------------------------------------------------------------------
   // Keystroke driver. A drawn gap follows each accepted item.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap     <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) predict_key(req_ch.payload.rx_byte);
         if (req_ch.valid && !req_ch.ready) begin
            // Hold the current item until the editor takes it.
         end else if (send_gap > 0) begin
            send_gap     <= send_gap - 1;
            req_ch.valid <= 1'b0;
         end else if (key_queue.size() > 0) begin
            req_ch.valid           <= 1'b1;
            req_ch.payload.rx_byte <= key_queue.pop_front();
            send_gap               <= idle_draw();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result monitor. Checks each accepted result item against the oldest
   // expectation and decides when to be ready again. The long hold-off is
   // counted here so that the editor backs up into its input.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      int unsigned      nw;
      int unsigned      nh;
      tle_pkg::rsp_type exp_r;
      if (reset) begin
         rsp_ch.ready   <= 1'b0;
         recv_wait      <= 0;
         hold_left      <= 0;
         long_hold_done <= 1'b0;
      end else begin
         nw = (recv_wait > 0) ? recv_wait - 1 : 0;
         nh = (hold_left > 0) ? hold_left - 1 : 0;
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (echo_expect_q.size() == 0) begin
               $display("%0t: unexpected result item, expected none, actual %p",
                        $time, rsp_ch.payload);
               err_count++;
            end else begin
               exp_r = echo_expect_q.pop_front();
               if (exp_r.target != rsp_ch.payload.target ||
                   exp_r.byte_value != rsp_ch.payload.byte_value ||
                   exp_r.overflow != rsp_ch.payload.overflow ||
                   exp_r.last != rsp_ch.payload.last) begin
                  $display("%0t: result mismatch, expected %p, actual %p",
                           $time, exp_r, rsp_ch.payload);
                  err_count++;
               end
            end
            nw = idle_draw();
         end
         if (long_hold_arm && !long_hold_done) begin
            nh = LongHold;
            long_hold_done <= 1'b1;
         end
         recv_wait    <= nw;
         hold_left    <= nh;
         rsp_ch.ready <= (nw == 0 && nh == 0);
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("terminal_line_editor verification failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus.
   // ------------------------------------------------------------------------

   // Waits until every item went in and every result came out, then lets the
   // editor finish work on keystrokes that cause no result.
   task automatic wait_quiet();
      do @(posedge clock);
      while (key_queue.size() > 0 || req_ch.valid || echo_expect_q.size() > 0);
      repeat (TailCycles) @(posedge clock);
   endtask

   task automatic set_capacity(input logic [4:0] cap);
      wait_quiet();
      csr_we    <= 1'b1;
      csr_wdata <= cap;
      capacity = cap;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic push_keys(input logic [7:0] k[]);
      foreach (k[i]) key_queue.push_back(k[i]);
   endtask

   // Mostly well-formed editing: text, arrows, deletes, enters, some noise.
   task automatic random_keys(input int unsigned count);
      int unsigned r;
      for (int unsigned i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 50) key_queue.push_back(8'($urandom_range(32, 126)));
         else if (r < 60) key_queue.push_back(tle_pkg::KeyBs);
         else if (r < 75) push_keys('{tle_pkg::KeyEsc, tle_pkg::ChLbr,
                                      ($urandom_range(0, 1) ? tle_pkg::ChC : tle_pkg::ChD)});
         else if (r < 80) push_keys('{tle_pkg::KeyEsc, tle_pkg::ChLbr, tle_pkg::Ch3,
                                      tle_pkg::ChTilde});
         else if (r < 85) key_queue.push_back(tle_pkg::KeyEnter);
         else if (r < 88) push_keys('{tle_pkg::KeyEsc, 8'($urandom), 8'($urandom)});
         else key_queue.push_back(8'($urandom));
      end
   endtask

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready   = 1'b0;
      csr_we         = 1'b0;
      csr_wdata      = '0;
      long_hold_arm  = 1'b0;
      no_idle        = 1'b0;
      err_count      = 0;
      cycle_count    = 0;
      result_count   = 0;
      line_len       = 0;
      cursor         = 0;
      esc_phase      = 0;
      capacity       = tle_pkg::CapReset;
      reset          = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed editing at the reset capacity: inserts, moves at both edges,
      // deletes, swallowed escape bytes, zero bytes, enters.
      push_keys('{8'h61, 8'hFF, 8'h01, tle_pkg::KeyEsc, tle_pkg::ChLbr, tle_pkg::ChC,
                  tle_pkg::KeyEsc, tle_pkg::ChLbr, tle_pkg::ChD, tle_pkg::KeyEsc,
                  tle_pkg::ChLbr, tle_pkg::Ch3, tle_pkg::ChTilde, 8'h00, tle_pkg::KeyBs,
                  tle_pkg::ChSpace, tle_pkg::KeyEsc, 8'h58, 8'h51, tle_pkg::ChD,
                  tle_pkg::KeyEsc, tle_pkg::ChLbr, tle_pkg::ChA, tle_pkg::KeyEnter,
                  tle_pkg::KeyEnter});
      push_keys('{tle_pkg::KeyBs, tle_pkg::KeyEsc, tle_pkg::ChLbr, tle_pkg::ChD,
                  tle_pkg::KeyEsc, tle_pkg::ChLbr, tle_pkg::Ch3, 8'h7A, tle_pkg::ChTilde,
                  8'h80, tle_pkg::KeyEsc, tle_pkg::ChLbr, tle_pkg::ChD, tle_pkg::KeyEsc,
                  tle_pkg::ChLbr, tle_pkg::ChB, tle_pkg::KeyEsc, 8'h00, tle_pkg::ChLbr,
                  tle_pkg::Ch3, tle_pkg::ChTilde, tle_pkg::KeyEsc, tle_pkg::ChLbr,
                  tle_pkg::ChC, tle_pkg::KeyEnter});

      // A full line of 24 reaches capacity.
      set_capacity(5'd31);
      for (int i = 0; i < 26; i++) key_queue.push_back(8'($urandom_range(33, 126)));
      random_keys(6);

      // Every insertion commits at once.
      set_capacity(5'd0);
      random_keys(4);
      set_capacity(5'd1);
      random_keys(3);

      // Lower the capacity below a partly typed line.
      set_capacity(5'd24);
      for (int i = 0; i < 10; i++) key_queue.push_back(8'($urandom_range(33, 126)));
      set_capacity(5'd3);
      push_keys('{tle_pkg::KeyEsc, tle_pkg::ChLbr, tle_pkg::ChD, 8'h71});
      random_keys(4);

      // Long receiver hold-off with the sender offering back to back.
      set_capacity(5'd20);
      no_idle <= 1'b1;
      long_hold_arm <= 1'b1;
      for (int i = 0; i < 18; i++) key_queue.push_back(8'($urandom_range(33, 126)));
      random_keys(4);
      wait_quiet();
      no_idle <= 1'b0;

      set_capacity(5'($urandom_range(2, 31)));
      random_keys(5);
      set_capacity(5'd24);
      random_keys(5);
      wait_quiet();

      if (err_count == 0) begin
         $display("terminal_line_editor verification clean");
      end else begin
         $display("terminal_line_editor verification failed");
      end
      $finish;
   end

endmodule
